>>> src/lrtc_pkg.sv
// Shared types, constants and the microcode program of the landing runaway
// throttle cap block. No dependencies; every other source file imports it.
package lrtc_pkg;

  // Fixed-point constants (Q16.16 unless noted)
  localparam logic signed [32:0] RunawayClimb  = 33'sd655360;   // 10 m
  localparam logic signed [31:0] ShedClimbNeg  = -32'sd16384;   // -0.25 m/s
  localparam logic signed [32:0] IBandPos      = 33'sd65536;    // 1.0
  localparam logic signed [32:0] IBandNeg      = -33'sd65536;
  localparam logic signed [32:0] ErrSatPos     = 33'sd1048576;  // gain clamps beyond this
  localparam logic signed [32:0] ErrSatNeg     = -33'sd1048576;
  localparam logic [16:0]        IMax          = 17'd68813;     // 1.05
  localparam logic signed [18:0] OneQ          = 19'sd65536;
  localparam logic signed [18:0] GainMin       = -19'sd3277;    // -0.05
  localparam logic signed [18:0] GainMax       = 19'sd85197;    // 1.3
  localparam logic [20:0]        Div10Mul      = 21'd1677722;   // ceil(2^24 / 10)
  localparam logic [16:0]        TickPeriodRst = 17'd164;

  // Configuration register indexes
  localparam logic CfgOptionEnable = 1'b0;
  localparam logic CfgTickPeriod   = 1'b1;

  // Microcode step addresses
  localparam int unsigned StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepStart  = 4'd0;
  localparam step_t StepEngage = 4'd1;
  localparam step_t StepErr    = 4'd2;
  localparam step_t StepTrack  = 4'd3;
  localparam step_t StepMulTp  = 4'd4;
  localparam step_t StepInteg  = 4'd5;
  localparam step_t StepGain   = 4'd6;
  localparam step_t StepCeil   = 4'd7;
  localparam step_t StepEmit   = 4'd8;
  localparam step_t StepClear  = 4'd9;
  localparam step_t LastStep   = StepClear;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_START,
    OP_ENGAGE,
    OP_ERR,
    OP_TRACK,
    OP_MUL_TP,
    OP_INTEG,
    OP_GAIN,
    OP_CEIL,
    OP_EMIT,
    OP_CLEAR
  } dp_op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_OPCODE,
    CND_NOT_ACTIVE,
    CND_NO_CAP
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    step_t  target;
    logic   last;
  } ucode_t;

  // Status flags the sequencer branches on
  typedef struct packed {
    logic opcode;
    logic active;
    logic cap;
  } dp_flags_t;

  typedef struct packed {
    logic               opcode;
    logic               radio_failsafe;
    logic               gcs_failsafe;
    logic               ekf_failsafe;
    logic               armed;
    logic signed [31:0] baro_altitude;
    logic signed [31:0] baro_climb_rate;
    logic signed [31:0] desired_down_velocity;
    logic [19:0]        descent_speed;
    logic [15:0]        hover_throttle;
    logic [15:0]        throttle_in;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] throttle_out;
    logic               cap_latched;
    logic               failsafe_engaged;
    logic               engaged_event;
    logic               capped_event;
  } out_item_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      StepStart:  w = '{OP_START,  CND_OPCODE,     StepClear, 1'b0};
      StepEngage: w = '{OP_ENGAGE, CND_NEVER,      StepStart, 1'b0};
      StepErr:    w = '{OP_ERR,    CND_NOT_ACTIVE, StepEmit,  1'b0};
      StepTrack:  w = '{OP_TRACK,  CND_NEVER,      StepStart, 1'b0};
      StepMulTp:  w = '{OP_MUL_TP, CND_NO_CAP,     StepEmit,  1'b0};
      StepInteg:  w = '{OP_INTEG,  CND_NEVER,      StepStart, 1'b0};
      StepGain:   w = '{OP_GAIN,   CND_NEVER,      StepStart, 1'b0};
      StepCeil:   w = '{OP_CEIL,   CND_NEVER,      StepStart, 1'b0};
      StepEmit:   w = '{OP_EMIT,   CND_NEVER,      StepStart, 1'b1};
      StepClear:  w = '{OP_CLEAR,  CND_ALWAYS,     StepEmit,  1'b0};
      default:    w = '{OP_EMIT,   CND_NEVER,      StepStart, 1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> src/lrtc_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on lrtc_pkg for the payload types.
interface lrtc_in_if import lrtc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrtc_out_if import lrtc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/lrtc_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on lrtc_pkg (ucode_rom, step and flag types).
module lrtc_sequencer import lrtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      hold_i,
  input  dp_flags_t flags_i,
  output ucode_t    uc_o,
  output logic      exec_o,
  output logic      busy_o
);

  logic   busy_q, busy_d;
  step_t  step_q, step_d;
  ucode_t uc;
  logic   jump;

  assign uc = ucode_rom(step_q);

  // Branch condition select
  always_comb begin
    case (uc.cond)
      CND_NEVER:      jump = 1'b0;
      CND_ALWAYS:     jump = 1'b1;
      CND_OPCODE:     jump = flags_i.opcode;
      CND_NOT_ACTIVE: jump = !flags_i.active;
      CND_NO_CAP:     jump = !flags_i.cap;
      default:        jump = 1'b0;
    endcase
  end

  // Step counter; the last step waits for the result register to drain
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = StepStart;
      end
    end else if (uc.last) begin
      if (!hold_i) begin
        busy_d = 1'b0;
      end
    end else begin
      step_d = jump ? uc.target : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepStart;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign uc_o   = uc;
  assign exec_o = busy_q && !(uc.last && hold_i);
  assign busy_o = busy_q;

  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= LastStep)
    else $error("sequencer step outside program");

  a_no_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !uc.last |=> busy_q)
    else $error("sequencer left before last step");

endmodule

>>> src/lrtc_datapath.sv
// Datapath: latches, altitude minimum, PI integrator and ceiling, with one
// shared divide-by-ten unit. Depends on lrtc_pkg; driven by lrtc_sequencer.
module lrtc_datapath import lrtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        exec_i,
  input  dp_op_e      op_i,
  input  in_item_t    item_i,
  input  logic        opt_en_i,
  input  logic [16:0] tick_i,
  output dp_flags_t   flags_o,
  output out_item_t   res_o
);

  // Architectural state
  logic               eng_q, eng_d;
  logic               cap_q, cap_d;
  logic               ev_eng_q, ev_eng_d;
  logic               ev_cap_q, ev_cap_d;
  logic signed [31:0] min_q, min_d;
  logic [16:0]        integ_q, integ_d;
  logic signed [17:0] ceil_q, ceil_d;

  // Scratch registers
  logic signed [21:0] err_q, err_d;
  logic               band_q, band_d;
  logic [32:0]        prod_q, prod_d;
  logic signed [17:0] g_q, g_d;

  logic signed [31:0] alt, climb, vdown;
  logic signed [32:0] err_full;
  logic signed [21:0] err_sat;
  logic               band;
  logic               err_neg;
  logic [20:0]        err_abs;
  logic               fs;
  logic               shed;
  logic signed [31:0] new_min;
  logic signed [32:0] rise;
  logic [20:0]        div_in;
  logic [41:0]        div_prod;
  logic [16:0]        div_q;
  logic signed [18:0] q_s;
  logic signed [18:0] integ_sum;
  logic signed [18:0] gain_sum;
  logic               g_neg;
  logic [16:0]        g_abs;
  logic [32:0]        c_prod;
  logic [16:0]        c_mag;
  logic               over;

  assign alt   = $signed(item_i.baro_altitude);
  assign climb = $signed(item_i.baro_climb_rate);
  assign vdown = $signed(item_i.desired_down_velocity);
  assign fs    = item_i.radio_failsafe | item_i.gcs_failsafe | item_i.ekf_failsafe;

  // Climb-rate error, saturated where the gain clamp makes the excess moot
  assign err_full = {climb[31], climb} + $signed({13'd0, item_i.descent_speed});
  always_comb begin
    if (err_full > ErrSatPos) begin
      err_sat = 22'(ErrSatPos);
    end else if (err_full < ErrSatNeg) begin
      err_sat = 22'(ErrSatNeg);
    end else begin
      err_sat = err_full[21:0];
    end
  end
  assign band = (err_full > IBandNeg) && (err_full < IBandPos);

  assign err_neg = err_q[21];
  assign err_abs = err_neg ? 21'(-err_q) : 21'(err_q);

  // Altitude minimum tracking and runaway detect
  assign shed    = vdown < ShedClimbNeg;
  assign new_min = (shed || alt < min_q) ? alt : min_q;
  assign rise    = {alt[31], alt} - {new_min[31], new_min};

  // Shared divide by ten: reciprocal multiply, exact for operands below 2^22
  assign div_in   = (op_i == OP_INTEG) ? {4'd0, prod_q[32:16]} : err_abs;
  assign div_prod = 42'(div_in) * 42'(Div10Mul);
  assign div_q    = div_prod[40:24];
  assign q_s      = err_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

  assign integ_sum = $signed({2'b00, integ_q}) + q_s;
  assign gain_sum  = OneQ - q_s - $signed({2'b00, integ_q});

  // Ceiling = gain * hover, truncated toward zero
  assign g_neg  = g_q[17];
  assign g_abs  = g_neg ? 17'(-g_q) : 17'(g_q);
  assign c_prod = 33'(g_abs) * 33'(item_i.hover_throttle);
  assign c_mag  = c_prod[32:16];

  // Operation decode
  always_comb begin
    eng_d    = eng_q;
    cap_d    = cap_q;
    ev_eng_d = ev_eng_q;
    ev_cap_d = ev_cap_q;
    min_d    = min_q;
    integ_d  = integ_q;
    ceil_d   = ceil_q;
    err_d    = err_q;
    band_d   = band_q;
    prod_d   = prod_q;
    g_d      = g_q;
    if (exec_i) begin
      case (op_i)
        OP_START: begin
          ev_eng_d = 1'b0;
          ev_cap_d = 1'b0;
        end
        OP_ENGAGE: begin
          if (!eng_q && opt_en_i && fs && item_i.armed) begin
            eng_d    = 1'b1;
            ev_eng_d = 1'b1;
            min_d    = alt;
          end
        end
        OP_ERR: begin
          err_d  = err_sat;
          band_d = band;
        end
        OP_TRACK: begin
          min_d = new_min;
          if (!cap_q && rise > RunawayClimb) begin
            cap_d    = 1'b1;
            ev_cap_d = 1'b1;
            integ_d  = '0;
          end
        end
        OP_MUL_TP: begin
          prod_d = 33'(err_abs[15:0]) * 33'(tick_i);
        end
        OP_INTEG: begin
          if (band_q) begin
            if (integ_sum < 0) begin
              integ_d = '0;
            end else if (integ_sum > $signed({2'b00, IMax})) begin
              integ_d = IMax;
            end else begin
              integ_d = integ_sum[16:0];
            end
          end
        end
        OP_GAIN: begin
          if (gain_sum < GainMin) begin
            g_d = 18'(GainMin);
          end else if (gain_sum > GainMax) begin
            g_d = 18'(GainMax);
          end else begin
            g_d = gain_sum[17:0];
          end
        end
        OP_CEIL: begin
          ceil_d = g_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
        end
        OP_CLEAR: begin
          eng_d = 1'b0;
          cap_d = 1'b0;
        end
        OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q    <= 1'b0;
      cap_q    <= 1'b0;
      ev_eng_q <= 1'b0;
      ev_cap_q <= 1'b0;
      min_q    <= '0;
      integ_q  <= '0;
      ceil_q   <= '0;
    end else begin
      eng_q    <= eng_d;
      cap_q    <= cap_d;
      ev_eng_q <= ev_eng_d;
      ev_cap_q <= ev_cap_d;
      min_q    <= min_d;
      integ_q  <= integ_d;
      ceil_q   <= ceil_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    band_q <= band_d;
    prod_q <= prod_d;
    g_q    <= g_d;
  end

  // Result and branch flags
  assign over = cap_q && ($signed({2'b00, item_i.throttle_in}) > ceil_q);

  assign res_o.throttle_out     = (!item_i.opcode && over) ? 17'(ceil_q)
                                                           : {1'b0, item_i.throttle_in};
  assign res_o.cap_latched      = cap_q;
  assign res_o.failsafe_engaged = eng_q;
  assign res_o.engaged_event    = ev_eng_q;
  assign res_o.capped_event     = ev_cap_q;

  assign flags_o.opcode = item_i.opcode;
  assign flags_o.active = eng_q && item_i.armed;
  assign flags_o.cap    = cap_q;

  a_cap_needs_engage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q |-> eng_q)
    else $error("cap latched without engaged failsafe");

  a_integ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= IMax)
    else $error("integrator above clamp");

endmodule

>>> src/landing_runaway_throttle_cap_core.sv
// Landing failsafe runaway throttle cap, top level.
// Paths: landing start/exit runs Start, Clear, Emit; inactive failsafe runs
// Start, Engage, Err, Emit; engaged adds Track, MulTp; capped adds Integ,
// Gain, Ceil. One datapath step per cycle, Emit waiting on the sink; no new
// input until the program ends. Reset (async, active low) clears latches,
// altitude minimum, integrator and ceiling; tick period 164.
module landing_runaway_throttle_cap_core import lrtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrtc_in_if.sink     in_i,
  lrtc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  logic        opt_en_q;
  logic [16:0] tick_q;
  in_item_t    item_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;

  logic        accept;
  logic        hold;
  logic        busy;
  logic        exec;
  logic        emit;
  ucode_t      uc;
  dp_flags_t   flags;
  out_item_t   res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_en_q <= 1'b0;
      tick_q   <= TickPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOptionEnable: opt_en_q <= cfg_data_i[0];
        CfgTickPeriod:   tick_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input capture
  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
    end
  end

  assign hold = out_valid_q && !out_o.ready;
  assign emit = exec && (uc.op == OP_EMIT);

  lrtc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .hold_i  (hold),
    .flags_i (flags),
    .uc_o    (uc),
    .exec_o  (exec),
    .busy_o  (busy)
  );

  lrtc_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .op_i     (uc.op),
    .item_i   (item_q),
    .opt_en_i (opt_en_q),
    .tick_i   (tick_q),
    .flags_o  (flags),
    .res_o    (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_cap_event_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.capped_event |-> out_o.data.cap_latched)
    else $error("capped event without cap latched");

endmodule

>>> sim/tb_landing_runaway_throttle_cap_core.sv
// Self-checking bench for landing_runaway_throttle_cap_core: a directed table,
// then randomized flight episodes with random source gaps and sink stalls.
// Depends on lrtc_pkg and the lrtc_in_if / lrtc_out_if interfaces.
`timescale 1ns / 100ps

module tb_landing_runaway_throttle_cap_core;
  import lrtc_pkg::*;

  // Scaled tick-period divisor: Q16.16 seconds times the 0.1 integral gain
  localparam longint TickGainDiv = 655360;
  localparam int     NumPhases   = 7;
  localparam int     PhaseTxns   = 265;
  // -1 means draw a random tick period for that phase
  localparam int     PhaseTick[NumPhases] = '{164, 65536, 1, -1, 0, -1, 164};
  localparam bit     PhaseOpt[NumPhases]  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  // Row of the directed plan: a register write or a transaction
  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [16:0] cfg_val;
    in_item_t    txn;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [16:0] cfg_data_i;

  lrtc_in_if  in_if ();
  lrtc_out_if out_if ();

  landing_runaway_throttle_cap_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state and register mirror
  bit     opt_en;
  longint tick_per;
  bit     engaged_st;
  bit     cap_st;
  longint min_alt_st;
  longint integ_st;
  longint ceiling_st;

  out_item_t pending_throttle_q[$];
  int        err_cnt;
  int        txn_cnt;
  int        result_cnt;
  int        engage_cnt;
  int        cap_cnt;
  int        limit_cnt;
  int        src_calm;
  int        sink_calm;

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_q(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Failsafe latch, altitude tracking and cap PI for one transaction
  function automatic out_item_t predict_throttle_cap(in_item_t t);
    out_item_t r;
    longint    alt;
    longint    climb;
    longint    vdown;
    longint    lspeed;
    longint    hover;
    longint    thr;
    longint    rate_err;
    longint    gain;
    longint    res;
    alt    = longint'(t.baro_altitude);
    climb  = longint'(t.baro_climb_rate);
    vdown  = longint'(t.desired_down_velocity);
    lspeed = longint'(t.descent_speed);
    hover  = longint'(t.hover_throttle);
    thr    = longint'(t.throttle_in);
    res    = thr;
    r.engaged_event = 1'b0;
    r.capped_event  = 1'b0;
    if (t.opcode) begin
      engaged_st = 1'b0;
      cap_st     = 1'b0;
    end else begin
      if (!engaged_st && opt_en && t.armed &&
          (t.radio_failsafe || t.gcs_failsafe || t.ekf_failsafe)) begin
        engaged_st      = 1'b1;
        r.engaged_event = 1'b1;
        min_alt_st      = alt;
        engage_cnt++;
      end
      if (engaged_st && t.armed) begin
        // still shedding a commanded climb: restart the minimum
        if (vdown < longint'(ShedClimbNeg) || alt < min_alt_st) min_alt_st = alt;
        if (!cap_st && alt - min_alt_st > longint'(RunawayClimb)) begin
          cap_st         = 1'b1;
          r.capped_event = 1'b1;
          integ_st       = 0;
          cap_cnt++;
        end
        if (cap_st) begin
          rate_err = climb + lspeed;
          if (rate_err > longint'(IBandNeg) && rate_err < longint'(IBandPos)) begin
            integ_st = clamp_q(integ_st + rate_err * tick_per / TickGainDiv, 0,
                               longint'(IMax));
          end
          gain = clamp_q(longint'(OneQ) - rate_err / 10 - integ_st,
                         longint'(GainMin), longint'(GainMax));
          ceiling_st = gain * hover / 65536;
        end
      end
      if (cap_st && thr > ceiling_st) begin
        res = ceiling_st;
        limit_cnt++;
      end
    end
    r.throttle_out     = res[16:0];
    r.cap_latched      = cap_st;
    r.failsafe_engaged = engaged_st;
    return r;
  endfunction

  function automatic in_item_t mk_txn(bit op, bit [2:0] fs, bit armed, int alt, int climb,
                                      int vdown, int ls, int hover, int thr);
    in_item_t t;
    t.opcode                = op;
    t.radio_failsafe        = fs[2];
    t.gcs_failsafe          = fs[1];
    t.ekf_failsafe          = fs[0];
    t.armed                 = armed;
    t.baro_altitude         = alt;
    t.baro_climb_rate       = climb;
    t.desired_down_velocity = vdown;
    t.descent_speed         = ls[19:0];
    t.hover_throttle        = hover[15:0];
    t.throttle_in           = thr[15:0];
    return t;
  endfunction

  function automatic out_item_t mk_res(int thr, bit cap, bit eng, bit eev, bit cev);
    out_item_t r;
    r.throttle_out     = thr[16:0];
    r.cap_latched      = cap;
    r.failsafe_engaged = eng;
    r.engaged_event    = eev;
    r.capped_event     = cev;
    return r;
  endfunction

  function automatic plan_row_t txn_row(in_item_t t);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = 1'b0;
    r.cfg_val = '0;
    r.txn     = t;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(in_item_t t, out_item_t w);
    plan_row_t r;
    r       = txn_row(t);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, logic [16:0] v);
    plan_row_t r;
    r         = txn_row('0);
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = v;
    return r;
  endfunction

  // Per-transaction random wait, with occasional runs of no waiting
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(39) == 0) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    return $urandom_range(12, 0);
  endfunction

  function automatic in_item_t noise_txn();
    return mk_txn($urandom_range(7) == 0, 3'($urandom), 1'($urandom), $urandom,
                  $urandom, $urandom, $urandom_range(655360), $urandom, $urandom);
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Offer one transaction; the prediction is queued on the accepting edge
  task automatic send_txn(in_item_t t, bit typed, out_item_t want);
    int        gap;
    out_item_t pred;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    pred = predict_throttle_cap(t);
    pending_throttle_q.push_back(typed ? want : pred);
    txn_cnt++;
  endtask

  // Hold off the source until every queued result has come back
  task automatic drain_results();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (pending_throttle_q.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [16:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgOptionEnable) opt_en = v[0];
    else tick_per = longint'(v);
  endtask

  // One landing episode: engage, drift up past the runaway height, with noise
  task automatic run_flight(int n);
    int       alt;
    int       ls;
    int       k;
    in_item_t t;
    alt = $signed($urandom) >>> 2;
    if ($urandom_range(1) == 0) send_txn(mk_txn(1'b1, 3'b000, 1'b1, alt, 0, 0, 0, 0, 0),
                                         1'b0, '0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        t = noise_txn();
      end else begin
        alt += $urandom_range(150000) - 20000;
        ls = $urandom_range(655360);
        t = mk_txn(1'b0, {$urandom_range(3) == 0, $urandom_range(3) == 0,
                          $urandom_range(3) == 0},
                   $urandom_range(15) != 0, alt,
                   ($urandom_range(4) == 0) ? $urandom : -ls + $urandom_range(180000) - 90000,
                   ($urandom_range(7) == 0) ? -$urandom_range(200000, 16383)
                                            : $urandom_range(100000) - 20000,
                   ls, $urandom, $urandom);
      end
      send_txn(t, 1'b0, '0);
    end
  endtask

  // Result sink: random stalls, every transaction checked against the queue
  initial begin
    out_item_t got;
    out_item_t want;
    int        stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = out_if.data;
      result_cnt++;
      if (pending_throttle_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected, actual throttle %0d",
                 $time, got.throttle_out);
      end else begin
        want = pending_throttle_q.pop_front();
        compare_field("throttle_out", want.throttle_out, got.throttle_out);
        compare_field("cap_latched", want.cap_latched, got.cap_latched);
        compare_field("failsafe_engaged", want.failsafe_engaged, got.failsafe_engaged);
        compare_field("engaged_event", want.engaged_event, got.engaged_event);
        compare_field("capped_event", want.capped_event, got.capped_event);
      end
    end
  end

  // Run limit
  initial begin
    #5000000;
    $display("tb_landing_runaway_throttle_cap_core NOT OK");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    plan_row_t plan[$];
    int        ph;
    int        sent;
    int        tp;
    opt_en      = 1'b0;
    tick_per    = longint'(TickPeriodRst);
    engaged_st  = 1'b0;
    cap_st      = 1'b0;
    min_alt_st  = 0;
    integ_st    = 0;
    ceiling_st  = 0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;

    // Directed plan: option off after reset, engage, cap threshold, clamps
    plan.push_back(typed_row(mk_txn(1'b0, 3'b111, 1'b1, 0, 0, 0, 0, 16'h8000, 16'h4321),
                             mk_res(16'h4321, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(typed_row(mk_txn(1'b1, 3'b000, 1'b1, 0, 0, 0, 0, 0, 16'hFFFF),
                             mk_res(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(cfg_row(CfgOptionEnable, 17'd1));
    plan.push_back(typed_row(mk_txn(1'b0, 3'b100, 1'b1, 0, 0, 0, 0, 16'h8000, 16'hFFFF),
                             mk_res(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0)));
    // exactly 10 m of ascent does not latch; one LSB more does
    plan.push_back(typed_row(mk_txn(1'b0, 3'b000, 1'b1, 655360, 0, 0, 0, 16'h8000, 16'h1000),
                             mk_res(16'h1000, 1'b0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(typed_row(mk_txn(1'b0, 3'b000, 1'b1, 655361, 0, 0, 0, 16'h8000, 16'hFFFF),
                             mk_res(16'h8000, 1'b1, 1'b1, 1'b0, 1'b1)));
    plan.push_back(typed_row(mk_txn(1'b0, 3'b000, 1'b1, 655361, 0, 0, 0, 16'h8000, 16'h7FFF),
                             mk_res(16'h7FFF, 1'b1, 1'b1, 1'b0, 1'b0)));
    // integrator band edges
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 700000, 65535, 0, 0, 16'h8000, 16'hFFFF)));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 700000, -65536, 0, 0, 16'h8000, 16'hFFFF)));
    // gain clamps: negative ceiling, then the upper limit
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 700000, 32'h7FFF_FFFF, 0, 655360,
                                  16'hFFFF, 0)));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 700000, 32'h8000_0000, 0, 0,
                                  16'hFFFF, 16'hFFFF)));
    // engaged but disarmed: cap still limits, nothing updates
    plan.push_back(txn_row(mk_txn(1'b0, 3'b111, 1'b0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0,
                                  16'h1234, 16'hFFFF)));
    plan.push_back(typed_row(mk_txn(1'b1, 3'b000, 1'b1, 0, 0, 0, 0, 16'h8000, 16'hABCD),
                             mk_res(16'hABCD, 1'b0, 1'b0, 1'b0, 1'b0)));
    // ground-station engage at the lowest altitude, climb just below shedding
    plan.push_back(txn_row(mk_txn(1'b0, 3'b010, 1'b1, 32'h8000_0000, 0, -16384, 0,
                                  16'h8000, 16'hFFFF)));
    plan.push_back(txn_row(mk_txn(1'b1, 3'b000, 1'b0, 0, 0, 0, 0, 0, 0)));
    // estimator engage, climb still being shed, then the highest altitude
    plan.push_back(txn_row(mk_txn(1'b0, 3'b001, 1'b1, -1000, 0, -16385, 0, 16'h8000, 16'hFFFF)));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 32'h7FFF_FFFF, -655360, 32'h7FFF_FFFF,
                                  655360, 16'hFFFF, 16'hFFFF)));
    plan.push_back(cfg_row(CfgTickPeriod, 17'd65536));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 32'h7FFF_FFFF, 50000, 0, 0,
                                  16'hFFFF, 16'hFFFF)));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 32'h7FFF_FFFF, 50000, 0, 0,
                                  16'hFFFF, 16'hFFFF)));
    // zero tick period freezes the integrator
    plan.push_back(cfg_row(CfgTickPeriod, 17'd0));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 32'h7FFF_FFFF, 30000, 0, 0,
                                  16'hFFFF, 16'hFFFF)));
    plan.push_back(cfg_row(CfgTickPeriod, 17'd1));
    plan.push_back(txn_row(mk_txn(1'b0, 3'b000, 1'b1, 32'h7FFF_FFFF, -30000, 0, 0,
                                  16'hFFFF, 16'hFFFF)));
    plan.push_back(cfg_row(CfgOptionEnable, 17'd0));
    plan.push_back(typed_row(mk_txn(1'b1, 3'b000, 1'b1, 0, 0, 0, 0, 0, 16'h0001),
                             mk_res(16'h0001, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(typed_row(mk_txn(1'b0, 3'b111, 1'b1, 0, 0, 0, 0, 0, 16'h5555),
                             mk_res(16'h5555, 1'b0, 1'b0, 1'b0, 1'b0)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_txn(plan[i].txn, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      tp = (PhaseTick[ph] < 0) ? $urandom_range(65536, 1) : PhaseTick[ph];
      write_cfg(CfgOptionEnable, 17'(PhaseOpt[ph]));
      write_cfg(CfgTickPeriod, 17'(tp));
      sent = 0;
      while (sent < PhaseTxns) begin
        run_flight($urandom_range(60, 10));
        sent = txn_cnt - ph * PhaseTxns - plan.size();
        if ($urandom_range(15) == 0) drain_results();
      end
    end

    drain_results();
    if (pending_throttle_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_throttle_q.size());
    end
    $display("Covered %0d transactions and %0d results over %0d register settings:",
             txn_cnt, result_cnt, NumPhases + 5);
    $display("  %0d failsafe engagements, %0d cap latches, %0d throttle limits",
             engage_cnt, cap_cnt, limit_cnt);
    if (err_cnt == 0) begin
      $display("tb_landing_runaway_throttle_cap_core OK");
    end else begin
      $display("tb_landing_runaway_throttle_cap_core NOT OK");
    end
    $finish;
  end

endmodule
